// ===== hw/rtl/bbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbps_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned HZ_W    = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CSTEP_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [HZ_W-1:0] ALARM_HI_HZ = HZ_W'(4000);
  localparam logic [HZ_W-1:0] ALARM_LO_HZ = HZ_W'(2000);
  localparam logic [HZ_W-1:0] CLEAR_HZ    = HZ_W'(800);

  localparam logic [TIME_W-1:0]  RST_ALARM_STEP_MS    = TIME_W'(50);
  localparam logic [COUNT_W-1:0] RST_ALARM_STEP_COUNT = COUNT_W'(60);
  localparam logic [TIME_W-1:0]  RST_CLEAR_BEEP_MS    = TIME_W'(100);
  localparam logic [TIME_W-1:0]  RST_CLEAR_GAP_MS     = TIME_W'(150);
  localparam logic [TIME_W-1:0]  RST_KEY_SHORT_MS     = TIME_W'(50);
  localparam logic [TIME_W-1:0]  RST_KEY_LONG_MS      = TIME_W'(200);
  localparam logic [HZ_W-1:0]    RST_KEY_LOW_HZ       = HZ_W'(1000);
  localparam logic [HZ_W-1:0]    RST_KEY_HIGH_HZ      = HZ_W'(1500);

  typedef enum logic [1:0] {
    MODE_TICK        = 2'd0,
    MODE_START_ALARM = 2'd1,
    MODE_START_CLEAR = 2'd2,
    MODE_START_KEY   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_STEP_MS    = 3'd0,
    CFG_ALARM_STEP_COUNT = 3'd1,
    CFG_CLEAR_BEEP_MS    = 3'd2,
    CFG_CLEAR_GAP_MS     = 3'd3,
    CFG_KEY_SHORT_MS     = 3'd4,
    CFG_KEY_LONG_MS      = 3'd5,
    CFG_KEY_LOW_HZ       = 3'd6,
    CFG_KEY_HIGH_HZ      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    mode_e mode;
    logic  key_long;
    logic  key_high;
  } in_item_t;

  typedef struct packed {
    logic            sound_on;
    logic [HZ_W-1:0] tone_hz;
    logic            busy_res;
  } out_item_t;

  typedef struct packed {
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [TIME_W-1:0]  alarm_step_ms;
    logic [COUNT_W-1:0] alarm_step_count;
    logic [TIME_W-1:0]  clear_beep_ms;
    logic [TIME_W-1:0]  clear_gap_ms;
    logic [TIME_W-1:0]  key_short_ms;
    logic [TIME_W-1:0]  key_long_ms;
    logic [HZ_W-1:0]    key_low_hz;
    logic [HZ_W-1:0]    key_high_hz;
  } cfg_regs_t;

  // Saturating millisecond count
  function automatic logic [TIME_W-1:0] bump(input logic [TIME_W-1:0] t);
    bump = (t == {TIME_W{1'b1}}) ? t : t + TIME_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bbps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bbps_in_if;
  import bbps_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbps_out_if;
  import bbps_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbps_cfg_if;
  import bbps_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/buzzer_beep_pattern_sequencer_core.sv =====
// Buzzer beep pattern sequencer.
// Channels: in_i carries one item per transfer (mode: tick, start alarm, start
// clear beep, start key beep, plus the key length and pitch selects). out_o
// carries one result per input item: sound_on, tone_hz and busy_res as they
// stand after the item is applied. cfg_i writes one of eight timing and pitch
// registers per transfer; it is always ready and should only be used while
// no item is in flight.
// Flow: an accepted item waits in the input register and is applied once the
// output register is free or being drained; its result is then registered and
// shown on out_o. Throughput: one item per cycle unless out_o is held off; the
// pattern update is a single pass of logic between the input and result registers.
// Reset: all patterns idle, drive silent, registers at their default values.
// Stall: while out_o is held off, one result waits in the output register and
// one more item waits in the input register; in_i drops ready only when both
// are full.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_beep_pattern_sequencer_core import bbps_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bbps_in_if.sink     in_i,
  bbps_out_if.source  out_o,
  bbps_cfg_if.sink    cfg_i
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  cfg_regs_t regs;
  logic      advance;

  // apply the held item when the output register is free or being drained
  assign advance     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~in_valid_q | advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  bbps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  bbps_pattern_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .regs_i    (regs),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbps_cfg_regs import bbps_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bbps_cfg_if.sink   cfg_i,
  output cfg_regs_t  regs_o
);

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.alarm_step_ms    <= RST_ALARM_STEP_MS;
      regs_q.alarm_step_count <= RST_ALARM_STEP_COUNT;
      regs_q.clear_beep_ms    <= RST_CLEAR_BEEP_MS;
      regs_q.clear_gap_ms     <= RST_CLEAR_GAP_MS;
      regs_q.key_short_ms     <= RST_KEY_SHORT_MS;
      regs_q.key_long_ms      <= RST_KEY_LONG_MS;
      regs_q.key_low_hz       <= RST_KEY_LOW_HZ;
      regs_q.key_high_hz      <= RST_KEY_HIGH_HZ;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.idx)
        CFG_ALARM_STEP_MS:    regs_q.alarm_step_ms    <= cfg_i.data.data;
        CFG_ALARM_STEP_COUNT: regs_q.alarm_step_count <= cfg_i.data.data[COUNT_W-1:0];
        CFG_CLEAR_BEEP_MS:    regs_q.clear_beep_ms    <= cfg_i.data.data;
        CFG_CLEAR_GAP_MS:     regs_q.clear_gap_ms     <= cfg_i.data.data;
        CFG_KEY_SHORT_MS:     regs_q.key_short_ms     <= cfg_i.data.data;
        CFG_KEY_LONG_MS:      regs_q.key_long_ms      <= cfg_i.data.data;
        CFG_KEY_LOW_HZ:       regs_q.key_low_hz       <= cfg_i.data.data;
        CFG_KEY_HIGH_HZ:      regs_q.key_high_hz      <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbps_pattern_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbps_pattern_engine import bbps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_en_i,
  input  wire in_item_t  item_i,
  input  wire cfg_regs_t regs_i,
  output out_item_t      result_o
);

  typedef struct packed {
    logic               alarm_active;
    logic [COUNT_W-1:0] alarm_step;
    logic [TIME_W-1:0]  alarm_timer;
    logic               clear_active;
    logic [CSTEP_W-1:0] clear_step;
    logic [TIME_W-1:0]  clear_timer;
    logic               key_active;
    logic               key_sounding;
    logic [TIME_W-1:0]  key_timer;
    logic               key_long_sel;
    logic               key_high_sel;
    logic               drive_on;
    logic [HZ_W-1:0]    drive_hz;
  } pat_state_t;

  pat_state_t st_q, st_d;

  always_comb begin
    logic [TIME_W-1:0] clear_wait;
    logic [TIME_W-1:0] key_len;
    st_d       = st_q;
    clear_wait = '0;
    key_len    = '0;
    case (item_i.mode)
      MODE_TICK: begin
        // alarm, clear, key in that order: last drive write wins
        if (st_d.alarm_active) begin
          st_d.alarm_timer = bump(st_d.alarm_timer);
          if (st_d.alarm_timer >= regs_i.alarm_step_ms) begin
            if (!st_d.alarm_step[0]) begin
              st_d.drive_on = 1'b1;
              st_d.drive_hz = st_d.alarm_step[1] ? ALARM_LO_HZ : ALARM_HI_HZ;
            end else begin
              st_d.drive_on = 1'b0;
              st_d.drive_hz = '0;
            end
            st_d.alarm_timer = '0;
            st_d.alarm_step  = st_d.alarm_step + COUNT_W'(1);
          end
          if (st_d.alarm_step >= regs_i.alarm_step_count) begin
            st_d.alarm_step   = '0;
            st_d.alarm_active = 1'b0;
          end
        end
        if (st_d.clear_active) begin
          st_d.clear_timer = bump(st_d.clear_timer);
          clear_wait = (st_d.clear_step == CSTEP_W'(2)) ? regs_i.clear_gap_ms
                                                         : regs_i.clear_beep_ms;
          if (st_d.clear_timer >= clear_wait) begin
            st_d.clear_timer = '0;
            if (!st_d.clear_step[0]) begin
              st_d.drive_on   = 1'b1;
              st_d.drive_hz   = CLEAR_HZ;
              st_d.clear_step = st_d.clear_step + CSTEP_W'(1);
            end else begin
              st_d.drive_on = 1'b0;
              st_d.drive_hz = '0;
              if (st_d.clear_step == CSTEP_W'(1)) begin
                st_d.clear_step = CSTEP_W'(2);
              end else begin
                st_d.clear_step   = '0;
                st_d.clear_active = 1'b0;
              end
            end
          end
        end
        if (st_d.key_active) begin
          key_len = st_d.key_long_sel ? regs_i.key_long_ms : regs_i.key_short_ms;
          if (!st_d.key_sounding) begin
            st_d.drive_on     = 1'b1;
            st_d.drive_hz     = st_d.key_high_sel ? regs_i.key_high_hz : regs_i.key_low_hz;
            st_d.key_timer    = '0;
            st_d.key_sounding = 1'b1;
          end else begin
            st_d.key_timer = bump(st_d.key_timer);
            if (st_d.key_timer >= key_len) begin
              st_d.drive_on     = 1'b0;
              st_d.drive_hz     = '0;
              st_d.key_sounding = 1'b0;
              st_d.key_active   = 1'b0;
              st_d.key_timer    = '0;
            end
          end
        end
      end
      MODE_START_ALARM: begin
        st_d.alarm_active = 1'b1;
        st_d.alarm_step   = '0;
        st_d.alarm_timer  = '0;
      end
      MODE_START_CLEAR: begin
        st_d.clear_active = 1'b1;
        st_d.clear_step   = '0;
        st_d.clear_timer  = '0;
      end
      MODE_START_KEY: begin
        st_d.key_active   = 1'b1;
        st_d.key_sounding = 1'b0;
        st_d.key_timer    = '0;
        st_d.key_long_sel = item_i.key_long;
        st_d.key_high_sel = item_i.key_high;
      end
      default: ;
    endcase
  end

  assign result_o.sound_on = st_d.drive_on;
  assign result_o.tone_hz  = st_d.drive_on ? st_d.drive_hz : '0;
  assign result_o.busy_res = st_d.alarm_active | st_d.clear_active | st_d.key_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_en_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire
